// ===== rtl/led_bloom_fade_pixel_macros.svh =====
// led_bloom_fade_pixel_macros.svh: assertion shorthands shared by the bloom/fade pixel RTL.
// Each macro expects i_clk, and all but LBF_ASSERT_RESET also i_rst_n, to exist in the module that uses it.
`ifndef LED_BLOOM_FADE_PIXEL_MACROS_SVH
`define LED_BLOOM_FADE_PIXEL_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define LBF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define LBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also covers the reset itself.
`define LBF_ASSERT_RESET(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lbf_pkg.sv =====
// lbf_pkg: widths, reset values, register indexes and stage payload types of the
// LED bloom/fade pixel core. No dependencies; every RTL file of the block imports it.
package lbf_pkg;

    localparam int TIME_W     = 16;
    localparam int PIX_W      = 10;
    localparam int DUR_W      = 16;
    localparam int LEDS_W     = 11;
    localparam int COL_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Longest strip the effect is laid out for; longer led_count values are clamped.
    localparam int MAX_LEDS = 1024;

    // Progress u is Q1.16, so 1.0 needs a seventeenth bit.
    localparam int              U_W   = 17;
    localparam logic [U_W-1:0]  U_ONE = U_W'(65536);

    // Centre is Q9.8 pixels, radius and distance are Q10.8; coverage and dim are Q1.8.
    localparam int CEN_W = 17;
    localparam int RAD_W = 18;
    localparam int DIM_W = 9;
    localparam int COV_W = 9;
    localparam int CD_W  = 17;

    // The divider resolves this many quotient bits per pipeline stage.
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = TIME_W / DIV_STEPS;

    localparam logic [DUR_W-1:0]  DUR_RST   = DUR_W'(5000);
    localparam logic [LEDS_W-1:0] LEDS_RST  = LEDS_W'(60);
    localparam logic [COL_W-1:0]  RED_RST   = COL_W'(8'h00);
    localparam logic [COL_W-1:0]  GREEN_RST = COL_W'(8'h28);
    localparam logic [COL_W-1:0]  BLUE_RST  = COL_W'(8'hff);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DURATION  = 3'd0,
        CFG_LED_COUNT = 3'd1,
        CFG_RED       = 3'd2,
        CFG_GREEN     = 3'd3,
        CFG_BLUE      = 3'd4
    } t_cfg_idx;

    // Divider to shaping stages.
    typedef struct packed {
        logic [U_W-1:0]   u;
        logic [PIX_W-1:0] pix;
        logic             done;
    } t_prog;

    // Shaping to shading stages.
    typedef struct packed {
        logic [RAD_W-1:0] radius;
        logic [DIM_W-1:0] dim;
        logic [PIX_W-1:0] pix;
        logic             done;
    } t_shape;

    // Strip geometry and colour seen by the shading stages.
    typedef struct packed {
        logic [LEDS_W-1:0] leds;
        logic [CEN_W-1:0]  centre;
        logic [COL_W-1:0]  red;
        logic [COL_W-1:0]  green;
        logic [COL_W-1:0]  blue;
    } t_shade_cfg;

    // Finished pixel.
    typedef struct packed {
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
        logic             done;
    } t_pixel;

endpackage

// ===== rtl/led_bloom_fade_pixel.sv =====
// led_bloom_fade_pixel: pixel colour of a power-on bloom, hold and fade effect on an
// LED strip. Takes one pixel beat per clock while the output is not stalled and returns
// one coloured beat for each. The core is a 12-stage pipeline: four divider stages work
// out progress u as time_ms / duration at four quotient bits per stage, four stages run
// the smoothstep and fade multipliers, and four stages form the soft-edged coverage and
// scale the colour. An item passes through the divider, shaping and shading stages in
// that order and the output is registered; while the output is not stalled, a new item
// is accepted every cycle. Every stage has its own valid bit and loads whenever it is
// empty or its successor moves, so an output stall fills empty stages first and the
// input stops only when all 12 hold an item. Configuration writes are always accepted
// in the cycle they are offered; the strip geometry derived from led_count is latched
// with the write. Registers must be written only while no items are in flight, since
// items in the pipe read them live.
// Depends on lbf_pkg, lbf_div, lbf_shape, lbf_shade and led_bloom_fade_pixel_macros.svh.
`include "led_bloom_fade_pixel_macros.svh"

module led_bloom_fade_pixel
    import lbf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // Pixel requests.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [15:0] time_ms, [25:16] pixel_index, [31:26] zero padding.
    input  logic [31:0]           s_axis_tdata,

    // Coloured pixels.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue.
    output logic [23:0]           m_axis_tdata,
    // [0] done_res.
    output logic [0:0]            m_axis_tuser,

    // Register writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [DUR_W-1:0]  r_dur;
    logic [LEDS_W-1:0] r_leds;
    logic [CEN_W-1:0]  r_centre;
    logic [RAD_W-1:0]  r_maxr;
    logic [COL_W-1:0]  r_red;
    logic [COL_W-1:0]  r_green;
    logic [COL_W-1:0]  r_blue;

    logic [LEDS_W-1:0] wr_leds;

    logic       div_valid;
    logic       div_ready;
    t_prog      div_prog;
    logic       shp_valid;
    logic       shp_ready;
    t_shape     shp_out;
    t_shade_cfg shade_cfg;
    t_pixel     pixel;

    // A zero duration stands for the default run time.
    function automatic logic [DUR_W-1:0] dur_eff(input logic [DUR_W-1:0] d);
        return (d == '0) ? DUR_RST : d;
    endfunction

    // Strip length clamped to at least one pixel and at most MAX_LEDS.
    function automatic logic [LEDS_W-1:0] leds_eff(input logic [LEDS_W-1:0] n);
        if (n == '0) begin
            return LEDS_W'(1);
        end else if (n > LEDS_W'(MAX_LEDS)) begin
            return LEDS_W'(MAX_LEDS);
        end else begin
            return n;
        end
    endfunction

    // Strip centre in Q9.8: half of (leds - 1) pixels.
    function automatic logic [CEN_W-1:0] centre_of(input logic [LEDS_W-1:0] n);
        logic [LEDS_W-1:0] m;
        m = n - LEDS_W'(1);
        return CEN_W'({m, 7'd0});
    endfunction

    // Full bloom reach: the centre plus one pixel.
    function automatic logic [RAD_W-1:0] maxr_of(input logic [LEDS_W-1:0] n);
        return RAD_W'(centre_of(n)) + RAD_W'(256);
    endfunction

    assign o_cfg_ready = 1'b1;
    assign wr_leds     = leds_eff(i_cfg_data[LEDS_W-1:0]);

    // Writes to indexes past the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur    <= DUR_RST;
            r_leds   <= LEDS_RST;
            r_centre <= centre_of(LEDS_RST);
            r_maxr   <= maxr_of(LEDS_RST);
            r_red    <= RED_RST;
            r_green  <= GREEN_RST;
            r_blue   <= BLUE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DURATION: begin
                    r_dur <= dur_eff(i_cfg_data[DUR_W-1:0]);
                end
                CFG_LED_COUNT: begin
                    r_leds   <= wr_leds;
                    r_centre <= centre_of(wr_leds);
                    r_maxr   <= maxr_of(wr_leds);
                end
                CFG_RED: begin
                    r_red <= i_cfg_data[COL_W-1:0];
                end
                CFG_GREEN: begin
                    r_green <= i_cfg_data[COL_W-1:0];
                end
                CFG_BLUE: begin
                    r_blue <= i_cfg_data[COL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    lbf_div u_div (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_time_ms     (s_axis_tdata[TIME_W-1:0]),
        .i_pixel_index (s_axis_tdata[TIME_W +: PIX_W]),
        .i_duration    (r_dur),
        .o_valid       (div_valid),
        .i_ready       (div_ready),
        .o_prog        (div_prog)
    );

    lbf_shape u_shape (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid),
        .o_ready (div_ready),
        .i_prog  (div_prog),
        .i_maxr  (r_maxr),
        .o_valid (shp_valid),
        .i_ready (shp_ready),
        .o_shape (shp_out)
    );

    assign shade_cfg.leds   = r_leds;
    assign shade_cfg.centre = r_centre;
    assign shade_cfg.red    = r_red;
    assign shade_cfg.green  = r_green;
    assign shade_cfg.blue   = r_blue;

    lbf_shade u_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (shp_valid),
        .o_ready (shp_ready),
        .i_shape (shp_out),
        .i_cfg   (shade_cfg),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_pixel (pixel)
    );

    assign m_axis_tdata = {pixel.blue, pixel.green, pixel.red};
    assign m_axis_tuser = pixel.done;

    // Past the end, u saturates and the fade dim reaches zero, so the pixel is black.
    `LBF_ASSERT_NOW(a_done_is_black, m_axis_tvalid && m_axis_tuser[0],
        m_axis_tdata == '0, "finished effect produced a lit pixel")
    // The input only stalls once every stage holds an item.
    `LBF_ASSERT_NOW(a_stall_means_full, !s_axis_tready, m_axis_tvalid,
        "input stalled with an empty output stage")
    `LBF_ASSERT_RESET(a_reset_empties, !i_rst_n, !m_axis_tvalid,
        "output valid after reset")

endmodule

// ===== rtl/lbf_div.sv =====
// lbf_div: pipelined restoring divider that turns time_ms into the Q1.16 progress u.
// Depends on lbf_pkg and led_bloom_fade_pixel_macros.svh.
`include "led_bloom_fade_pixel_macros.svh"

module lbf_div
    import lbf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [TIME_W-1:0] i_time_ms,
    input  logic [PIX_W-1:0]  i_pixel_index,
    input  logic [DUR_W-1:0]  i_duration,
    output logic              o_valid,
    input  logic              i_ready,
    output t_prog             o_prog
);

    logic [DIV_STAGES-1:0] r_vld;
    logic [DIV_STAGES:0]   stg_ready;
    logic [DIV_STAGES-1:0] vld_in;

    logic [DUR_W:0]       r_rem  [DIV_STAGES];
    logic [TIME_W-1:0]    r_quo  [DIV_STAGES];
    logic [PIX_W-1:0]     r_pix  [DIV_STAGES];
    logic [DIV_STAGES-1:0] r_done;

    logic [DUR_W:0]        rem_in [DIV_STAGES];
    logic [TIME_W-1:0]     quo_in [DIV_STAGES];
    logic [PIX_W-1:0]      pix_in [DIV_STAGES];
    logic [DIV_STAGES-1:0] done_in;
    logic [DUR_W:0]        n_rem  [DIV_STAGES];
    logic [TIME_W-1:0]     n_quo  [DIV_STAGES];

    logic          first_done;
    logic [DUR_W:0] dur_ext;

    // Once time reaches the duration the quotient saturates at 1.0, so the
    // remainder starts at zero and every quotient bit comes out clear.
    assign first_done = (i_time_ms >= i_duration);
    assign dur_ext    = {1'b0, i_duration};

    always_comb begin
        rem_in[0]  = first_done ? '0 : {1'b0, i_time_ms};
        quo_in[0]  = '0;
        pix_in[0]  = i_pixel_index;
        done_in[0] = first_done;
        vld_in[0]  = i_valid;
        for (int k = 1; k < DIV_STAGES; k++) begin
            rem_in[k]  = r_rem[k - 1];
            quo_in[k]  = r_quo[k - 1];
            pix_in[k]  = r_pix[k - 1];
            done_in[k] = r_done[k - 1];
            vld_in[k]  = r_vld[k - 1];
        end
    end

    // The remainder stays below the divisor, so doubling it fits in 17 bits.
    always_comb begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            n_rem[k] = rem_in[k];
            n_quo[k] = quo_in[k];
            for (int j = 0; j < DIV_STEPS; j++) begin
                n_rem[k] = {n_rem[k][DUR_W-1:0], 1'b0};
                n_quo[k] = {n_quo[k][TIME_W-2:0], 1'b0};
                if (n_rem[k] >= dur_ext) begin
                    n_rem[k]    = n_rem[k] - dur_ext;
                    n_quo[k][0] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        stg_ready[DIV_STAGES] = i_ready;
        for (int k = DIV_STAGES - 1; k >= 0; k--) begin
            stg_ready[k] = !r_vld[k] || stg_ready[k + 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                if (stg_ready[k]) begin
                    r_vld[k] <= vld_in[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (stg_ready[k]) begin
                r_rem[k]  <= n_rem[k];
                r_quo[k]  <= n_quo[k];
                r_pix[k]  <= pix_in[k];
                r_done[k] <= done_in[k];
            end
        end
    end

    assign o_ready      = stg_ready[0];
    assign o_valid      = r_vld[DIV_STAGES-1];
    assign o_prog.u     = r_done[DIV_STAGES-1] ? U_ONE : {1'b0, r_quo[DIV_STAGES-1]};
    assign o_prog.pix   = r_pix[DIV_STAGES-1];
    assign o_prog.done  = r_done[DIV_STAGES-1];

    `LBF_ASSERT_NOW(a_div_sat_zero, r_vld[DIV_STAGES-1] && r_done[DIV_STAGES-1],
        r_quo[DIV_STAGES-1] == '0, "saturated item left quotient bits set")
    `LBF_ASSERT_NOW(a_div_full_stall, !o_ready, &r_vld,
        "divider refused a beat while one of its stages was empty")
    `LBF_ASSERT_NEXT(a_div_keep, o_valid && !i_ready, o_valid,
        "divider dropped a stalled item")

endmodule

// ===== rtl/lbf_shape.sv =====
// lbf_shape: four pipeline stages that turn progress u into the bloom radius and fade dim.
// Depends on lbf_pkg.
module lbf_shape
    import lbf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_prog            i_prog,
    input  logic [RAD_W-1:0] i_maxr,
    output logic             o_valid,
    input  logic             i_ready,
    output t_shape           o_shape
);

    localparam int NSTG = 4;

    // Phase edges in Q1.16: 5u < 3.0 is u below ceil(0.6), 25u >= 18.0 is u from ceil(0.72).
    localparam logic [U_W-1:0] U_BLOOM_LIMIT = U_W'((3 * 65536 + 4) / 5);
    localparam logic [U_W-1:0] U_FADE_FROM   = U_W'((18 * 65536 + 24) / 25);

    // floor(5u/3) and floor(25d/7) as reciprocal multiplies; exact over the ranges used.
    localparam int P_MUL   = 873815;
    localparam int P_SHIFT = 19;
    localparam int K_MUL   = 14979675;
    localparam int K_SHIFT = 22;

    localparam int P_W  = 16;
    localparam int D_W  = 15;
    localparam int K_W  = 16;
    localparam int W_W  = 18;
    localparam int S_W  = 17;
    localparam int PP_W = P_W + 20;
    localparam int KP_W = D_W + 24;
    localparam int SP_W = P_W + W_W;
    localparam int RP_W = S_W + RAD_W;

    localparam logic [W_W-1:0]   W_BASE   = W_W'(196608);
    localparam logic [DIM_W-1:0] DIM_FULL = DIM_W'(256);

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] vld_in;
    logic [NSTG:0]   stg_ready;

    logic [PP_W-1:0]  n1_pprod;
    logic [KP_W-1:0]  n1_kprod;
    logic [P_W-1:0]   r1_p;
    logic [K_W-1:0]   r1_k;
    logic             r1_bloom;
    logic             r1_fade;
    logic [PIX_W-1:0] r1_pix;
    logic             r1_done;

    logic [2*P_W-1:0] n2_pp;
    logic [2*K_W-1:0] n2_kk;
    logic [P_W-1:0]   r2_p2;
    logic [W_W-1:0]   r2_w;
    logic [DIM_W-1:0] r2_dim;
    logic             r2_bloom;
    logic [PIX_W-1:0] r2_pix;
    logic             r2_done;

    logic [SP_W-1:0]  n3_sprod;
    logic [S_W-1:0]   r3_s;
    logic [DIM_W-1:0] r3_dim;
    logic             r3_bloom;
    logic [PIX_W-1:0] r3_pix;
    logic             r3_done;

    logic [RP_W-1:0]  n4_rprod;
    logic [RAD_W-1:0] r4_radius;
    logic [DIM_W-1:0] r4_dim;
    logic [PIX_W-1:0] r4_pix;
    logic             r4_done;

    assign vld_in = {r_vld[NSTG-2:0], i_valid};

    always_comb begin
        stg_ready[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            stg_ready[k] = !r_vld[k] || stg_ready[k + 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (stg_ready[k]) begin
                    r_vld[k] <= vld_in[k];
                end
            end
        end
    end

    // Stage 1: eased position p and fade ramp k. Each is only meaningful in its own
    // phase, so the inputs are left unmasked and the phase flags pick later.
    assign n1_pprod = PP_W'(i_prog.u[P_W-1:0]) * PP_W'(P_MUL);
    assign n1_kprod = KP_W'(D_W'(U_ONE - i_prog.u)) * KP_W'(K_MUL);

    always_ff @(posedge i_clk) begin
        if (stg_ready[0]) begin
            r1_p     <= n1_pprod[P_SHIFT +: P_W];
            r1_k     <= n1_kprod[K_SHIFT +: K_W];
            r1_bloom <= (i_prog.u < U_BLOOM_LIMIT);
            r1_fade  <= (i_prog.u >= U_FADE_FROM);
            r1_pix   <= i_prog.pix;
            r1_done  <= i_prog.done;
        end
    end

    // Stage 2: p squared, the (3 - 2p) factor, and the quadratic dim.
    assign n2_pp = (2*P_W)'(r1_p) * (2*P_W)'(r1_p);
    assign n2_kk = (2*K_W)'(r1_k) * (2*K_W)'(r1_k);

    always_ff @(posedge i_clk) begin
        if (stg_ready[1]) begin
            r2_p2    <= n2_pp[P_W +: P_W];
            r2_w     <= W_BASE - W_W'({r1_p, 1'b0});
            r2_dim   <= r1_fade ? DIM_W'(n2_kk[2*K_W-1 -: 8]) : DIM_FULL;
            r2_bloom <= r1_bloom;
            r2_pix   <= r1_pix;
            r2_done  <= r1_done;
        end
    end

    // Stage 3: smoothstep value s.
    assign n3_sprod = SP_W'(r2_p2) * SP_W'(r2_w);

    always_ff @(posedge i_clk) begin
        if (stg_ready[2]) begin
            r3_s     <= n3_sprod[16 +: S_W];
            r3_dim   <= r2_dim;
            r3_bloom <= r2_bloom;
            r3_pix   <= r2_pix;
            r3_done  <= r2_done;
        end
    end

    // Stage 4: radius, full reach outside the bloom phase.
    assign n4_rprod = RP_W'(r3_s) * RP_W'(i_maxr);

    always_ff @(posedge i_clk) begin
        if (stg_ready[3]) begin
            r4_radius <= r3_bloom ? n4_rprod[16 +: RAD_W] : i_maxr;
            r4_dim    <= r3_dim;
            r4_pix    <= r3_pix;
            r4_done   <= r3_done;
        end
    end

    assign o_ready        = stg_ready[0];
    assign o_valid        = r_vld[NSTG-1];
    assign o_shape.radius = r4_radius;
    assign o_shape.dim    = r4_dim;
    assign o_shape.pix    = r4_pix;
    assign o_shape.done   = r4_done;

endmodule

// ===== rtl/lbf_shade.sv =====
// lbf_shade: four pipeline stages from radius and dim to the pixel's scaled colour.
// Depends on lbf_pkg.
module lbf_shade
    import lbf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_shape     i_shape,
    input  t_shade_cfg i_cfg,
    output logic       o_valid,
    input  logic       i_ready,
    output t_pixel     o_pixel
);

    localparam int NSTG   = 4;
    localparam int POS_W  = PIX_W + 8;
    localparam int DIFF_W = POS_W + 1;
    localparam int C_W    = RAD_W + 2;
    localparam int CP_W   = 2 * COV_W;
    localparam int MP_W   = COL_W + CD_W;

    localparam logic signed [C_W-1:0] HALF_PIX  = C_W'(128);
    localparam logic signed [C_W-1:0] COV_LIMIT = C_W'(256);
    localparam logic [COV_W-1:0]      COV_FULL  = COV_W'(256);

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] vld_in;
    logic [NSTG:0]   stg_ready;

    logic [POS_W-1:0]         n1_pos;
    logic signed [DIFF_W-1:0] n1_diff;
    logic signed [DIFF_W-1:0] n1_neg;
    logic [RAD_W-1:0]         r1_dist;
    logic [RAD_W-1:0]         r1_radius;
    logic [DIM_W-1:0]         r1_dim;
    logic                     r1_inside;
    logic                     r1_done;

    logic signed [C_W-1:0] n2_c;
    logic [COV_W-1:0]      r2_cov;
    logic [DIM_W-1:0]      r2_dim;
    logic                  r2_inside;
    logic                  r2_done;

    logic [CP_W-1:0] n3_cd;
    logic [CD_W-1:0] r3_cd;
    logic            r3_inside;
    logic            r3_done;

    logic [MP_W-1:0] n4_red;
    logic [MP_W-1:0] n4_green;
    logic [MP_W-1:0] n4_blue;
    t_pixel          r4_pix;

    assign vld_in = {r_vld[NSTG-2:0], i_valid};

    always_comb begin
        stg_ready[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            stg_ready[k] = !r_vld[k] || stg_ready[k + 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (stg_ready[k]) begin
                    r_vld[k] <= vld_in[k];
                end
            end
        end
    end

    // Stage 1: distance of the pixel from the strip centre, in Q10.8.
    assign n1_pos  = {i_shape.pix, 8'd0};
    assign n1_diff = $signed({1'b0, n1_pos}) - $signed({2'b00, i_cfg.centre});
    assign n1_neg  = -n1_diff;

    always_ff @(posedge i_clk) begin
        if (stg_ready[0]) begin
            r1_dist   <= n1_diff[DIFF_W-1] ? n1_neg[RAD_W-1:0] : n1_diff[RAD_W-1:0];
            r1_radius <= i_shape.radius;
            r1_dim    <= i_shape.dim;
            r1_inside <= (LEDS_W'(i_shape.pix) < i_cfg.leds);
            r1_done   <= i_shape.done;
        end
    end

    // Stage 2: soft edge coverage, clamped to [0, 1].
    assign n2_c = $signed({2'b00, r1_radius}) - $signed({2'b00, r1_dist}) + HALF_PIX;

    always_ff @(posedge i_clk) begin
        if (stg_ready[1]) begin
            if (n2_c[C_W-1]) begin
                r2_cov <= '0;
            end else if (n2_c > COV_LIMIT) begin
                r2_cov <= COV_FULL;
            end else begin
                r2_cov <= n2_c[COV_W-1:0];
            end
            r2_dim    <= r1_dim;
            r2_inside <= r1_inside;
            r2_done   <= r1_done;
        end
    end

    // Stage 3: combined brightness, at most 1.0 in Q1.16.
    assign n3_cd = CP_W'(r2_cov) * CP_W'(r2_dim);

    always_ff @(posedge i_clk) begin
        if (stg_ready[2]) begin
            r3_cd     <= n3_cd[CD_W-1:0];
            r3_inside <= r2_inside;
            r3_done   <= r2_done;
        end
    end

    // Stage 4: scale each component and truncate; pixels past the strip are black.
    assign n4_red   = MP_W'(i_cfg.red)   * MP_W'(r3_cd);
    assign n4_green = MP_W'(i_cfg.green) * MP_W'(r3_cd);
    assign n4_blue  = MP_W'(i_cfg.blue)  * MP_W'(r3_cd);

    always_ff @(posedge i_clk) begin
        if (stg_ready[3]) begin
            r4_pix.red   <= r3_inside ? n4_red[16 +: COL_W]   : '0;
            r4_pix.green <= r3_inside ? n4_green[16 +: COL_W] : '0;
            r4_pix.blue  <= r3_inside ? n4_blue[16 +: COL_W]  : '0;
            r4_pix.done  <= r3_done;
        end
    end

    assign o_ready = stg_ready[0];
    assign o_valid = r_vld[NSTG-1];
    assign o_pixel = r4_pix;

endmodule
